// File: hdl/cpoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpoc_pkg;

   // fixed widths of the transaction fields
   localparam int FIELD_WIDTH     = 32;
   localparam int RSP_COUNT_WIDTH = 16;
   localparam int STATUS_WIDTH    = 2;

   // smallest polygon that can be judged
   localparam int MIN_VERTICES = 3;

   // cross product units: the running turn and the two closing turns
   localparam int TURN_COUNT      = 3;
   localparam int TURN_RUN        = 0;
   localparam int TURN_WRAP_END   = 1;
   localparam int TURN_WRAP_START = 2;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_CONVEX  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_CONCAVE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_TOO_FEW = 2'd2;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] vertex_x;
      logic signed [FIELD_WIDTH-1:0] vertex_y;
      logic                          last_vertex;
   } cpoc_req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]    status;
      logic [RSP_COUNT_WIDTH-1:0] vertex_count;
   } cpoc_rsp_type;

   // control that travels with a vertex through the pipeline
   typedef struct packed {
      logic                       turn_en;
      logic                       wrap_en;
      logic                       last;
      logic                       too_few;
      logic [RSP_COUNT_WIDTH-1:0] count;
   } cpoc_ctl_type;

endpackage

`default_nettype wire

// File: hdl/cpoc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cpoc_front #(
   parameter int COORD_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire cpoc_pkg::cpoc_req_type        req_data,
   input  wire logic                          p_ready,
   output logic                               s1_valid,
   output cpoc_pkg::cpoc_ctl_type             s1_ctl,
   output logic signed [COORD_WIDTH-1:0]      s1_x [5],
   output logic signed [COORD_WIDTH-1:0]      s1_y [5]
);
   import cpoc_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] CNT_TWO = COUNT_WIDTH'(2);
   localparam logic [COUNT_WIDTH-1:0] CNT_MIN = COUNT_WIDTH'(MIN_VERTICES);

   logic                           accept;
   logic signed [COORD_WIDTH-1:0]  vx;
   logic signed [COORD_WIDTH-1:0]  vy;
   logic [COUNT_WIDTH-1:0]         count_ff;
   logic [COUNT_WIDTH-1:0]         count_in;
   logic [COUNT_WIDTH-1:0]         count_inc;
   logic [COUNT_WIDTH+RSP_COUNT_WIDTH-1:0] count_wide;
   logic [RSP_COUNT_WIDTH-1:0]     count_rpt;
   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   cpoc_ctl_type                   s1_ctl_ff;
   cpoc_ctl_type                   s1_ctl_in;
   logic signed [COORD_WIDTH-1:0]  first_x_ff, first_y_ff;
   logic signed [COORD_WIDTH-1:0]  second_x_ff, second_y_ff;
   logic signed [COORD_WIDTH-1:0]  older_x_ff, older_y_ff;
   logic signed [COORD_WIDTH-1:0]  newer_x_ff, newer_y_ff;
   logic signed [COORD_WIDTH-1:0]  s1_x_ff [5];
   logic signed [COORD_WIDTH-1:0]  s1_y_ff [5];

   assign req_ready = !s1_valid_ff || p_ready;
   assign accept    = req_valid && req_ready;
   assign vx        = req_data.vertex_x[COORD_WIDTH-1:0];
   assign vy        = req_data.vertex_y[COORD_WIDTH-1:0];

   // saturating vertex counter
   assign count_inc  = (count_ff == CNT_MAX) ? count_ff : count_ff + CNT_ONE;
   assign count_wide = {{RSP_COUNT_WIDTH{1'b0}}, count_inc};
   assign count_rpt  = (|(count_wide >> RSP_COUNT_WIDTH)) ? '1
                                                          : count_wide[RSP_COUNT_WIDTH-1:0];

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = req_data.last_vertex ? '0 : count_inc;
      end
      s1_valid_in = accept || (s1_valid_ff && !p_ready);
      s1_ctl_in.turn_en = (count_ff >= CNT_TWO);
      s1_ctl_in.wrap_en = req_data.last_vertex && (count_inc > CNT_MIN);
      s1_ctl_in.last    = req_data.last_vertex;
      s1_ctl_in.too_few = (count_inc < CNT_MIN);
      s1_ctl_in.count   = count_rpt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // vertex history and stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         if (count_ff == '0) begin
            first_x_ff <= vx;
            first_y_ff <= vy;
         end
         if (count_ff == CNT_ONE) begin
            second_x_ff <= vx;
            second_y_ff <= vy;
         end
         older_x_ff <= newer_x_ff;
         older_y_ff <= newer_y_ff;
         newer_x_ff <= vx;
         newer_y_ff <= vy;
         s1_ctl_ff  <= s1_ctl_in;
         s1_x_ff[0] <= older_x_ff;
         s1_y_ff[0] <= older_y_ff;
         s1_x_ff[1] <= newer_x_ff;
         s1_y_ff[1] <= newer_y_ff;
         s1_x_ff[2] <= vx;
         s1_y_ff[2] <= vy;
         s1_x_ff[3] <= first_x_ff;
         s1_y_ff[3] <= first_y_ff;
         s1_x_ff[4] <= second_x_ff;
         s1_y_ff[4] <= second_y_ff;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_ctl   = s1_ctl_ff;
   assign s1_x     = s1_x_ff;
   assign s1_y     = s1_y_ff;

endmodule

`default_nettype wire

// File: hdl/cpoc_turn.sv
`timescale 1ns / 1ps
`default_nettype none

module cpoc_turn #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           load_en,
   input  wire logic signed [COORD_WIDTH-1:0]  pt_x [3],
   input  wire logic signed [COORD_WIDTH-1:0]  pt_y [3],
   output logic signed [2*COORD_WIDTH+1:0]     prod_lhs,
   output logic signed [2*COORD_WIDTH+1:0]     prod_rhs
);
   import cpoc_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * COORD_WIDTH + 2;

   logic signed [DW-1:0] ax, ay, bx, by;
   logic signed [PW-1:0] lhs_in, rhs_in;
   logic signed [PW-1:0] lhs_ff, rhs_ff;

   // edge vectors from the first point, one bit wider so they never wrap
   always_comb begin
      ax     = DW'(pt_x[1]) - DW'(pt_x[0]);
      ay     = DW'(pt_y[1]) - DW'(pt_y[0]);
      bx     = DW'(pt_x[2]) - DW'(pt_x[0]);
      by     = DW'(pt_y[2]) - DW'(pt_y[0]);
      lhs_in = ax * by;
      rhs_in = bx * ay;
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
      end
   end

   assign prod_lhs = lhs_ff;
   assign prod_rhs = rhs_ff;

endmodule

`default_nettype wire

// File: hdl/cpoc_judge.sv
`timescale 1ns / 1ps
`default_nettype none

module cpoc_judge #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           s1_valid,
   input  wire cpoc_pkg::cpoc_ctl_type         s1_ctl,
   output logic                                p_ready,
   input  wire logic signed [2*COORD_WIDTH+1:0] prod_lhs [cpoc_pkg::TURN_COUNT],
   input  wire logic signed [2*COORD_WIDTH+1:0] prod_rhs [cpoc_pkg::TURN_COUNT],
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output cpoc_pkg::cpoc_rsp_type              rsp_data
);
   import cpoc_pkg::*;

   logic                  p_valid_ff, p_valid_in;
   cpoc_ctl_type          p_ctl_ff;
   logic                  p_leave;
   logic                  out_free;
   logic [TURN_COUNT-1:0] turn_ok;
   logic                  item_ok;
   logic                  flag_ff, flag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cpoc_rsp_type          rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign p_leave  = p_valid_ff && (!p_ctl_ff.last || out_free);
   assign p_ready  = !p_valid_ff || p_leave;

   always_comb begin
      for (int i = 0; i < TURN_COUNT; i++) begin
         turn_ok[i] = (prod_lhs[i] > prod_rhs[i]);
      end
      item_ok = (!p_ctl_ff.turn_en || turn_ok[TURN_RUN]) &&
                (!p_ctl_ff.wrap_en || (turn_ok[TURN_WRAP_END] && turn_ok[TURN_WRAP_START]));

      p_valid_in   = (s1_valid && p_ready) || (p_valid_ff && !p_leave);
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (p_leave) begin
         if (p_ctl_ff.last) begin
            flag_in                  = 1'b1;
            rsp_valid_in             = 1'b1;
            rsp_data_in.vertex_count = p_ctl_ff.count;
            if (p_ctl_ff.too_few) begin
               rsp_data_in.status = STATUS_TOO_FEW;
            end else if (flag_ff && item_ok) begin
               rsp_data_in.status = STATUS_CONVEX;
            end else begin
               rsp_data_in.status = STATUS_CONCAVE;
            end
         end else begin
            flag_in = flag_ff && item_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         flag_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= p_valid_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid && p_ready) begin
         p_ctl_ff <= s1_ctl;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hdl/convex_polygon_orientation_check_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// result path: a last vertex passes the input window, product and result registers
// throughput: one vertex per cycle unless rsp_ready holds back a verdict;
//    three cross product units (two multipliers each) work on every vertex
//    in a single pass, so nothing is shared
// reset: clears the vertex counter and all pipeline valids, sets the turn flag;
//    vertex history registers are not reset and are written before use

module convex_polygon_orientation_check_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire cpoc_pkg::cpoc_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output cpoc_pkg::cpoc_rsp_type      rsp_data
);
   import cpoc_pkg::*;

   localparam int PW = 2 * COORD_WIDTH + 2;

   // stage 1: vertex window plus control
   logic                          s1_valid;
   cpoc_ctl_type                  s1_ctl;
   logic signed [COORD_WIDTH-1:0] s1_x [5];
   logic signed [COORD_WIDTH-1:0] s1_y [5];

   // stage 2 handshake and products
   logic                          p_ready;
   logic                          p_load;
   logic signed [PW-1:0]          prod_lhs [TURN_COUNT];
   logic signed [PW-1:0]          prod_rhs [TURN_COUNT];

   // front end: counts vertices, keeps first, second and the last two vertices,
   // and captures the window (older, newer, new, first, second) for stage 1
   cpoc_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .p_ready   (p_ready),
      .s1_valid  (s1_valid),
      .s1_ctl    (s1_ctl),
      .s1_x      (s1_x),
      .s1_y      (s1_y)
   );

   assign p_load = s1_valid && p_ready;

   // turn k looks at window slots k, k+1, k+2:
   //    running turn (older, newer, new), closing turns (newer, new, first)
   //    and (new, first, second)
   for (genvar k = 0; k < TURN_COUNT; k++) begin : g_turn
      logic signed [COORD_WIDTH-1:0] tx [3];
      logic signed [COORD_WIDTH-1:0] ty [3];

      assign tx[0] = s1_x[k];
      assign tx[1] = s1_x[k+1];
      assign tx[2] = s1_x[k+2];
      assign ty[0] = s1_y[k];
      assign ty[1] = s1_y[k+1];
      assign ty[2] = s1_y[k+2];

      cpoc_turn #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_turn (
         .clock    (clock),
         .load_en  (p_load),
         .pt_x     (tx),
         .pt_y     (ty),
         .prod_lhs (prod_lhs[k]),
         .prod_rhs (prod_rhs[k])
      );
   end

   // compare products, fold into the polygon flag, hold the result
   cpoc_judge #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_judge (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_ctl    (s1_ctl),
      .p_ready   (p_ready),
      .prod_lhs  (prod_lhs),
      .prod_rhs  (prod_rhs),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // too few vertices must come with a count below the minimum
   a_too_few_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_TOO_FEW)
         |-> (rsp_data.vertex_count < RSP_COUNT_WIDTH'(MIN_VERTICES)))
      else $error("too-few status with a full vertex count");

   // a judged polygon has at least the minimum vertex count
   a_judged_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_TOO_FEW)
         |-> (rsp_data.vertex_count >= RSP_COUNT_WIDTH'(MIN_VERTICES)))
      else $error("polygon judged with too few vertices");

   // back pressure only when stage 1 holds a vertex
   a_ready_low : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid)
      else $error("input stalled with empty stage 1");

   // a result appears only after a last vertex left stage 1
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(p_ready, 1))
      else $error("result raised without a product stage transfer");

endmodule

`default_nettype wire

// File: tb/convexity_verdict_checker.sv
`timescale 1ns / 1ps

module convexity_verdict_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  cpoc_pkg::cpoc_req_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  cpoc_pkg::cpoc_rsp_type rsp_data,
   output int                     mismatch_count,
   output int                     verdicts_pending
);
   import cpoc_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] x;
      logic signed [FIELD_WIDTH-1:0] y;
   } point_type;

   point_type                  first_pt;
   point_type                  second_pt;
   point_type                  older_pt;
   point_type                  newer_pt;
   logic [RSP_COUNT_WIDTH-1:0] vertices_seen;
   logic                       all_left;
   cpoc_rsp_type               expected_verdicts[$];
   cpoc_rsp_type               oldest_verdict;

   // exact sign of (b-a) x (c-a); differences need one extra bit
   function automatic logic turns_left(point_type a, point_type b, point_type c);
      logic signed [FIELD_WIDTH+1:0]   ux;
      logic signed [FIELD_WIDTH+1:0]   uy;
      logic signed [FIELD_WIDTH+1:0]   wx;
      logic signed [FIELD_WIDTH+1:0]   wy;
      logic signed [2*FIELD_WIDTH+3:0] lhs;
      logic signed [2*FIELD_WIDTH+3:0] rhs;
      ux  = $signed(b.x) - $signed(a.x);
      uy  = $signed(b.y) - $signed(a.y);
      wx  = $signed(c.x) - $signed(a.x);
      wy  = $signed(c.y) - $signed(a.y);
      lhs = ux * wy;
      rhs = wx * uy;
      return lhs > rhs;
   endfunction

   task automatic absorb_vertex(input cpoc_req_type item);
      point_type    p;
      cpoc_rsp_type verdict;
      p.x = item.vertex_x;
      p.y = item.vertex_y;
      if (vertices_seen == 0) begin
         first_pt = p;
      end else if (vertices_seen == 1) begin
         second_pt = p;
      end else if (!turns_left(older_pt, newer_pt, p)) begin
         all_left = 1'b0;
      end
      older_pt = newer_pt;
      newer_pt = p;
      if (vertices_seen != '1) begin
         vertices_seen++;
      end
      if (item.last_vertex) begin
         if (vertices_seen < MIN_VERTICES) begin
            verdict.status = STATUS_TOO_FEW;
         end else begin
            // triangles have no closing turns beyond the one already seen
            if (vertices_seen != MIN_VERTICES) begin
               if (!turns_left(older_pt, newer_pt, first_pt)) all_left = 1'b0;
               if (!turns_left(newer_pt, first_pt, second_pt)) all_left = 1'b0;
            end
            verdict.status = all_left ? STATUS_CONVEX : STATUS_CONCAVE;
         end
         verdict.vertex_count = vertices_seen;
         expected_verdicts.insert(expected_verdicts.size(), verdict);
         vertices_seen = '0;
         all_left      = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         first_pt       = '0;
         second_pt      = '0;
         older_pt       = '0;
         newer_pt       = '0;
         vertices_seen  = '0;
         all_left       = 1'b1;
         mismatch_count = 0;
         expected_verdicts.delete();
      end else begin
         if (req_valid && req_ready) begin
            absorb_vertex(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected verdict status %0d count %0d", $realtime,
                           rsp_data.status, rsp_data.vertex_count);
               end
            end else begin
               oldest_verdict = expected_verdicts.pop_front();
               if (rsp_data.status !== oldest_verdict.status ||
                   rsp_data.vertex_count !== oldest_verdict.vertex_count) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: verdict mismatch: expected status %0d count %0d,",
                              $realtime, oldest_verdict.status,
                              oldest_verdict.vertex_count,
                              " got status %0d count %0d",
                              rsp_data.status, rsp_data.vertex_count);
                  end
               end
            end
         end
      end
      verdicts_pending = expected_verdicts.size();
   end

endmodule

// File: tb/convex_polygon_orientation_check_unit_tb.sv
`timescale 1ns / 1ps

module convex_polygon_orientation_check_unit_tb;
   import cpoc_pkg::*;

   localparam int CLOCK_PERIOD     = 12;
   localparam int RESET_CYCLES     = 3;
   // a last vertex passes the window, product and result registers to become a verdict
   localparam int DRAIN_CYCLES     = 10;
   // far beyond the longest stall either side can produce at 88 percent idling
   localparam int STALL_LIMIT      = 2000;
   localparam int VERTICES_PER_MIX = 560;

   localparam logic signed [FIELD_WIDTH-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [FIELD_WIDTH-1:0] COORD_MAX = 32'sh7fff_ffff;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   cpoc_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   cpoc_rsp_type rsp_data;

   int mismatch_count;
   int verdicts_pending;
   int stall_cycles = 0;

   // idle percentages of the two sides, changed per phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // vertices of the polygon being assembled for sending
   logic signed [FIELD_WIDTH-1:0] outline_x[$];
   logic signed [FIELD_WIDTH-1:0] outline_y[$];

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   convex_polygon_orientation_check_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   convexity_verdict_checker verdicts (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .mismatch_count   (mismatch_count),
      .verdicts_pending (verdicts_pending)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // cycles since the last transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // one vertex transaction; valid stays up from one vertex to the next
   // unless an idle cycle is drawn, so it is never dropped and raised in one step
   task automatic send_vertex(input logic signed [FIELD_WIDTH-1:0] x,
                              input logic signed [FIELD_WIDTH-1:0] y,
                              input logic                          last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{vertex_x: x, vertex_y: y, last_vertex: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic add_point(input logic signed [FIELD_WIDTH-1:0] x,
                            input logic signed [FIELD_WIDTH-1:0] y);
      outline_x.insert(outline_x.size(), x);
      outline_y.insert(outline_y.size(), y);
   endtask

   // sends the assembled polygon, flagging its final vertex, and empties it
   task automatic send_outline();
      int count;
      count = outline_x.size();
      for (int k = 0; k < count; k++) begin
         send_vertex(outline_x[k], outline_y[k], k == count - 1);
      end
      outline_x.delete();
      outline_y.delete();
   endtask

   task automatic swap_points(input int a, input int b);
      logic signed [FIELD_WIDTH-1:0] tx;
      logic signed [FIELD_WIDTH-1:0] ty;
      tx           = outline_x[a];
      ty           = outline_y[a];
      outline_x[a] = outline_x[b];
      outline_y[a] = outline_y[b];
      outline_x[b] = tx;
      outline_y[b] = ty;
   endtask

   // random magnitude up to cap, spread over many orders of size
   function automatic longint pick_scale(input longint cap);
      longint lim;
      lim = cap >> $urandom_range(0, 20);
      if (lim < 1) lim = 1;
      return longint'($urandom_range(1, int'(lim)));
   endfunction

   // mix of polygons until the vertex budget is used up: mostly convex ones,
   // some convex ones spoiled on purpose, some noise and some that are too short
   task automatic random_polygons(input int vertex_budget);
      int     sent;
      int     pick;
      int     n;
      int     quarter;
      int     start;
      int     k;
      longint base_x;
      longint base_y;
      longint step;
      longint bend;
      longint idx;
      longint u;
      longint v;
      longint rx;
      longint ry;
      sent = 0;
      while (sent < vertex_budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            // one or two stray vertices, or a random cloud of points
            n = (pick < 10) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            for (k = 0; k < n; k++) begin
               add_point($urandom, $urandom);
            end
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
            // points (i*step, bend*i*i) on a convex chain, counterclockwise;
            // spans stay below 2^28 so any offset within 2^30 keeps them in range
            base_x  = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
            base_y  = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
            step    = pick_scale((64'sd1 << 28) / n);
            bend    = pick_scale((64'sd1 << 28) / (n * n));
            quarter = $urandom_range(0, 3);
            // start anywhere on the ring so the closing turns land everywhere
            start   = $urandom_range(0, n - 1);
            for (k = 0; k < n; k++) begin
               idx = (start + k) % n;
               u   = idx * step;
               v   = bend * idx * idx;
               // quarter turns keep the orientation
               case (quarter)
                  0: begin
                     rx = u;
                     ry = v;
                  end
                  1: begin
                     rx = -v;
                     ry = u;
                  end
                  2: begin
                     rx = -u;
                     ry = -v;
                  end
                  default: begin
                     rx = v;
                     ry = -u;
                  end
               endcase
               add_point(32'(base_x + rx), 32'(base_y + ry));
            end
            if (pick < 45) begin
               case ($urandom_range(0, 2))
                  0: begin
                     // walk the ring clockwise
                     for (k = 0; k < n / 2; k++) begin
                        swap_points(k, n - 1 - k);
                     end
                  end
                  1: begin
                     // repeated vertex gives a zero turn
                     k = $urandom_range(1, n - 1);
                     outline_x[k] = outline_x[k - 1];
                     outline_y[k] = outline_y[k - 1];
                  end
                  default: begin
                     k = $urandom_range(0, n - 2);
                     swap_points(k, k + 1);
                  end
               endcase
            end
         end
         sent += outline_x.size();
         send_outline();
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver mostly stalled
      send_idle_pct = 6;
      recv_idle_pct = 88;

      // single vertex and vertex pair at the coordinate extremes: too few
      add_point(COORD_MIN, COORD_MAX);
      send_outline();
      add_point(COORD_MAX, COORD_MIN);
      add_point(COORD_MIN, COORD_MAX);
      send_outline();

      // full-range triangle, counterclockwise then clockwise
      add_point(COORD_MIN, COORD_MIN);
      add_point(COORD_MAX, COORD_MIN);
      add_point(COORD_MAX, COORD_MAX);
      send_outline();
      add_point(COORD_MIN, COORD_MIN);
      add_point(COORD_MAX, COORD_MAX);
      add_point(COORD_MAX, COORD_MIN);
      send_outline();

      // full-range square, largest cross products in both closing turns
      add_point(COORD_MIN, COORD_MIN);
      add_point(COORD_MAX, COORD_MIN);
      add_point(COORD_MAX, COORD_MAX);
      add_point(COORD_MIN, COORD_MAX);
      send_outline();

      // three collinear vertices, zero turn
      add_point(0, 0);
      add_point(10, 0);
      add_point(20, 0);
      add_point(20, 10);
      send_outline();

      // running turns fine, turn back onto the first vertex is not
      add_point(0, 0);
      add_point(10, 0);
      add_point(10, 10);
      add_point(5, -5);
      send_outline();

      // only the turn through the first and second vertex fails
      add_point(0, 0);
      add_point(10, 0);
      add_point(10, 10);
      add_point(-5, -2);
      send_outline();

      random_polygons(VERTICES_PER_MIX);

      // sender mostly idle, receiver mostly ready
      send_idle_pct = 88;
      recv_idle_pct = 6;
      random_polygons(VERTICES_PER_MIX);

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_polygons(VERTICES_PER_MIX);

      req_valid <= 1'b0;
      @(posedge clock);

      wait (verdicts_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && verdicts_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/cpoc_pkg.sv
hdl/cpoc_front.sv
hdl/cpoc_turn.sv
hdl/cpoc_judge.sv
hdl/convex_polygon_orientation_check_unit.sv
tb/convexity_verdict_checker.sv
tb/convex_polygon_orientation_check_unit_tb.sv
